// ===== hw/rtl/vsfc_pkg.sv =====
// shared types, constants and defaults for the video sync frame capture block
package vsfc_pkg;

   localparam int DEF_FRAME_DECIMATION  = 1;
   localparam int DEF_VSYNC_RUN         = 2;
   localparam int DEF_HSYNC_LOW_SAMPLES = 93;
   localparam int DEF_LINE_PERIOD       = 734;

   localparam int SAMPLE_W = 16;
   localparam int PIXEL_W  = 8;
   localparam int DIM_W    = 11;
   localparam int RUN_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] DIM_MAX       = '1;
   localparam logic [DIM_W-1:0] WIDTH_RESET   = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET  = 11'd480;
   localparam logic [RUN_W-1:0] RUN_MAX       = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 2'd2;

   typedef enum logic [4:0] {
      ST_UNKNOWN   = 5'b00001,
      ST_OUT_FRAME = 5'b00010,
      ST_SKIP      = 5'b00100,
      ST_OUT_LINE  = 5'b01000,
      ST_IN_LINE   = 5'b10000
   } frame_state_type;

   typedef struct packed {
      logic [DIM_W-1:0] sensor_width;
      logic [DIM_W-1:0] sensor_height;
      logic             filter_enable;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] raw_sample;
      logic                vsync_level;
      logic                hsync_level;
   } item_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic [DIM_W-1:0]   pixel_row;
      logic [DIM_W-1:0]   pixel_col;
      logic               pixel_valid;
      logic               frame_done;
      logic               frame_truncated;
      logic               line_error;
   } result_type;

endpackage

// ===== hw/rtl/vsfc_if.sv =====
// channel interfaces for sample input, pixel result and register writes
interface vsfc_req_if import vsfc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] raw_sample;
   logic                vsync_level;
   logic                hsync_level;

   modport source (output valid, raw_sample, vsync_level, hsync_level, input ready);
   modport sink   (input valid, raw_sample, vsync_level, hsync_level, output ready);
endinterface

interface vsfc_rsp_if import vsfc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;
   logic [DIM_W-1:0]   pixel_row;
   logic [DIM_W-1:0]   pixel_col;
   logic               pixel_valid;
   logic               frame_done;
   logic               frame_truncated;
   logic               line_error;

   modport source (output valid, pixel_value, pixel_row, pixel_col, pixel_valid,
                   frame_done, frame_truncated, line_error, input ready);
   modport sink   (input valid, pixel_value, pixel_row, pixel_col, pixel_valid,
                   frame_done, frame_truncated, line_error, output ready);
endinterface

interface vsfc_csr_if import vsfc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/video_sync_frame_capture_top.sv =====
// top level of the video sync frame capture block
//
// req_bus carries one raw sensor sample per transaction with its vsync and
// hsync levels; rsp_bus returns exactly one result per sample: the pixel
// (bits 11..4), its row and column, and the frame done, truncated and
// line error flags. csr_bus writes sensor_width (index 0), sensor_height
// (index 1) and filter_enable (index 2); it is always ready. It must be
// written while no sample is in flight; the block does not enforce this.
// A sample is held in an input register, runs through the frame state
// machine and lands in the result register. One sample per cycle is
// sustained while the receiver takes results; the state update sits
// between the input and result registers.
// Reset clears the frame state to unknown, all counters to zero and the
// registers to 640 x 480 with filtering off. When the receiver stalls the
// result register holds, the input register still takes one more sample,
// and then req ready drops until the result is taken.
module video_sync_frame_capture_top import vsfc_pkg::*; #(
   parameter int FRAME_DECIMATION  = DEF_FRAME_DECIMATION,
   parameter int VSYNC_RUN         = DEF_VSYNC_RUN,
   parameter int HSYNC_LOW_SAMPLES = DEF_HSYNC_LOW_SAMPLES,
   parameter int LINE_PERIOD       = DEF_LINE_PERIOD
) (
   input  logic       clock,
   input  logic       reset,
   vsfc_req_if.sink   req_bus,
   vsfc_rsp_if.source rsp_bus,
   vsfc_csr_if.sink   csr_bus
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type result;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_take;

   vsfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   vsfc_core #(
      .FRAME_DECIMATION  (FRAME_DECIMATION),
      .VSYNC_RUN         (VSYNC_RUN),
      .HSYNC_LOW_SAMPLES (HSYNC_LOW_SAMPLES),
      .LINE_PERIOD       (LINE_PERIOD)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .item    (item_ff),
      .result  (result)
   );

   assign advance       = item_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !item_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      item_in.raw_sample  = req_bus.raw_sample;
      item_in.vsync_level = req_bus.vsync_level;
      item_in.hsync_level = req_bus.hsync_level;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
      rsp_in = result;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.pixel_value     = rsp_ff.pixel_value;
   assign rsp_bus.pixel_row       = rsp_ff.pixel_row;
   assign rsp_bus.pixel_col       = rsp_ff.pixel_col;
   assign rsp_bus.pixel_valid     = rsp_ff.pixel_valid;
   assign rsp_bus.frame_done      = rsp_ff.frame_done;
   assign rsp_bus.frame_truncated = rsp_ff.frame_truncated;
   assign rsp_bus.line_error      = rsp_ff.line_error;

endmodule

// ===== hw/rtl/vsfc_csr.sv =====
// configuration register bank
module vsfc_csr import vsfc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   vsfc_csr_if.sink     csr_bus,
   output cfg_type      cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_SENSOR_WIDTH:  cfg_in.sensor_width  = csr_bus.data;
            CSR_SENSOR_HEIGHT: cfg_in.sensor_height = csr_bus.data;
            CSR_FILTER_ENABLE: cfg_in.filter_enable = csr_bus.data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_width  <= WIDTH_RESET;
         cfg_ff.sensor_height <= HEIGHT_RESET;
         cfg_ff.filter_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/vsfc_core.sv =====
// frame and line state machine with pixel result logic
module vsfc_core import vsfc_pkg::*; #(
   parameter int FRAME_DECIMATION  = DEF_FRAME_DECIMATION,
   parameter int VSYNC_RUN         = DEF_VSYNC_RUN,
   parameter int HSYNC_LOW_SAMPLES = DEF_HSYNC_LOW_SAMPLES,
   parameter int LINE_PERIOD       = DEF_LINE_PERIOD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  cfg_type    cfg,
   input  item_type   item,
   output result_type result
);

   localparam int PHASE_W = (FRAME_DECIMATION > 1) ? $clog2(FRAME_DECIMATION) : 1;
   localparam int LP_W    = $clog2(LINE_PERIOD);
   localparam int LP_START =
      (VSYNC_RUN + LINE_PERIOD * 1024 - HSYNC_LOW_SAMPLES - 1) % LINE_PERIOD;
   localparam logic [LP_W-1:0]    LP_LAST    = LP_W'(LINE_PERIOD - 1);
   localparam logic [LP_W-1:0]    LP_LOAD    = LP_W'(LP_START);
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(FRAME_DECIMATION - 1);
   localparam logic [RUN_W-1:0]   RUN_START  = RUN_W'(VSYNC_RUN);

   frame_state_type    state_ff, state_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [DIM_W-1:0]   row_ff, row_in;
   logic [DIM_W-1:0]   col_ff, col_in;
   logic [LP_W-1:0]    lp_ff, lp_in;
   logic [RUN_W-1:0]   run_next;
   logic [PHASE_W-1:0] phase_next;

   always_comb begin
      state_in = state_ff;
      run_in   = run_ff;
      phase_in = phase_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      lp_in    = (lp_ff == LP_LAST) ? '0 : lp_ff + 1'b1;
      result   = '0;
      run_next   = '0;
      phase_next = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 1'b1;

      unique case (state_ff)
         ST_OUT_FRAME: begin
            if (item.vsync_level) begin
               run_next = (run_ff == RUN_MAX) ? run_ff : run_ff + 1'b1;
            end
            run_in = run_next;
            if (run_next >= RUN_START) begin
               run_in   = '0;
               phase_in = phase_next;
               if (phase_next == '0) begin
                  state_in = ST_OUT_LINE;
                  lp_in    = LP_LOAD;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SKIP: begin
            if (!item.vsync_level) begin
               row_in   = '0;
               col_in   = '0;
               run_in   = '0;
               state_in = ST_OUT_FRAME;
            end
         end
         ST_OUT_LINE: begin
            if (!item.vsync_level) begin
               result.frame_done      = 1'b1;
               result.frame_truncated = 1'b1;
               row_in   = '0;
               col_in   = '0;
               run_in   = '0;
               state_in = ST_OUT_FRAME;
            end else if (item.hsync_level) begin
               state_in = ST_IN_LINE;
               if (cfg.filter_enable && lp_in != '0) begin
                  row_in   = '0;
                  col_in   = '0;
                  run_in   = '0;
                  state_in = ST_UNKNOWN;
                  result.line_error = 1'b1;
               end
            end
         end
         ST_IN_LINE: begin
            if (item.hsync_level) begin
               if (col_ff < cfg.sensor_width && row_ff < cfg.sensor_height) begin
                  result.pixel_valid = 1'b1;
                  result.pixel_value = item.raw_sample[11:4];
                  result.pixel_row   = row_ff;
                  result.pixel_col   = col_ff;
               end
               if (col_ff != DIM_MAX) begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               col_in   = '0;
               row_in   = row_ff + 1'b1;
               state_in = ST_OUT_LINE;
            end
            if (row_in == cfg.sensor_height) begin
               result.frame_done = 1'b1;
               row_in   = '0;
               col_in   = '0;
               run_in   = '0;
               state_in = ST_UNKNOWN;
            end
         end
         default: begin
            state_in = (!item.vsync_level && !item.hsync_level) ? ST_OUT_FRAME : ST_UNKNOWN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_UNKNOWN;
         run_ff   <= '0;
         phase_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         lp_ff    <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         run_ff   <= run_in;
         phase_ff <= phase_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         lp_ff    <= lp_in;
      end
   end

endmodule
